// ----- design/obfe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obfe_pkg
// shared types, widths and codes for the order book feature engine
// ----------------------------------------------------------------------------
package obfe_pkg;

  localparam int NUM_W = 80;   // divider dividend width
  localparam int DEN_W = 33;   // divider divisor width
  localparam int BITS_W = 7;   // divider step count width
  localparam int SUM_W = 48;   // rolling sum width
  localparam int OFI_W = 34;
  localparam int SPR_W = 32;
  localparam int QI_W = 18;
  localparam int MICRO_W = 47;

  localparam logic [2:0] EMIT_MID = 3'd0;
  localparam logic [2:0] EMIT_SPR = 3'd1;
  localparam logic [2:0] EMIT_OFI = 3'd2;
  localparam logic [2:0] EMIT_MICRO = 3'd3;
  localparam logic [2:0] EMIT_QI = 3'd4;
  localparam logic [2:0] EMIT_MEAN = 3'd5;

  localparam logic [3:0] LAST_K = 4'd8;

  typedef struct packed {
    logic       load;
    logic       qi_start;
    logic       qi_save;
    logic       mul_a;
    logic       mul_b;
    logic       mc_start;
    logic       mc_save;
    logic       emit;
    logic [2:0] emit_sel;
    logic       mem_rd;
    logic       sum_upd;
    logic       mean_start;
    logic       hist_commit;
    logic [3:0] k;
  } obfe_cmd_t;

  typedef struct packed {
    logic den_zero;
    logic is_top;
    logic is_last;
    logic div_done;
    logic out_free;
  } obfe_stat_t;

  // signal of rolling slot k: 0 ofi, 1 spread, 2 level 0 imbalance
  function automatic logic [1:0] k_sig(input logic [3:0] k);
    logic [1:0] s;
    case (k)
      4'd0, 4'd1, 4'd2: s = 2'd0;
      4'd3, 4'd4, 4'd5: s = 2'd1;
      default: s = 2'd2;
    endcase
    return s;
  endfunction

  // window of rolling slot k: 0 short, 1 mid, 2 long
  function automatic logic [1:0] k_win(input logic [3:0] k);
    logic [1:0] w;
    case (k)
      4'd0, 4'd3, 4'd6: w = 2'd0;
      4'd1, 4'd4, 4'd7: w = 2'd1;
      default: w = 2'd2;
    endcase
    return w;
  endfunction

endpackage

// ----- design/obfe_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obfe_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module obfe_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [obfe_pkg::NUM_W-1:0]       num,
  input  logic [obfe_pkg::DEN_W-1:0]       den,
  input  logic [obfe_pkg::BITS_W-1:0]      bits,
  output logic                             done,
  output logic [obfe_pkg::NUM_W-1:0]       quot
);

  logic [obfe_pkg::NUM_W-1:0]  acc;
  logic [obfe_pkg::DEN_W-1:0]  rem;
  logic [obfe_pkg::DEN_W-1:0]  dreg;
  logic [obfe_pkg::BITS_W-1:0] cnt;
  logic                        busy;
  logic [obfe_pkg::DEN_W:0]    trial;
  logic                        ge;

  // dividend is left aligned, so once the step count runs out acc holds the quotient
  assign trial = {rem, acc[obfe_pkg::NUM_W-1]};
  assign ge = trial >= {1'b0, dreg};
  assign quot = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == obfe_pkg::BITS_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= num;
      rem <= '0;
      dreg <= den;
      cnt <= bits;
    end else if (busy) begin
      acc <= {acc[obfe_pkg::NUM_W-2:0], ge};
      rem <= ge ? obfe_pkg::DEN_W'(trial - {1'b0, dreg}) : trial[obfe_pkg::DEN_W-1:0];
      cnt <= cnt - obfe_pkg::BITS_W'(1);
    end
  end

endmodule

// ----- design/obfe_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obfe_dp
// feature datapath: operand registers, history rings, sums, output register
// ----------------------------------------------------------------------------
module obfe_dp #(
  parameter int MAX_LEVEL_COUNT = 8,
  parameter int WINDOW_SHORT = 16,
  parameter int WINDOW_MID = 64,
  parameter int WINDOW_LONG = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  obfe_pkg::obfe_cmd_t  cmd,
  output obfe_pkg::obfe_stat_t stat,
  input  logic                 cfg_we,
  input  logic [3:0]           cfg_data,
  input  logic [30:0]          bid_price,
  input  logic [30:0]          ask_price,
  input  logic [30:0]          bid_size,
  input  logic [30:0]          ask_size,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [4:0]           feature_index,
  output logic signed [63:0]   feature_value,
  output logic                 last_of_tick
);

  localparam int HD0 = (WINDOW_SHORT > WINDOW_MID) ? WINDOW_SHORT : WINDOW_MID;
  localparam int HD = (HD0 > WINDOW_LONG) ? HD0 : WINDOW_LONG;
  localparam int PTR_W = (HD > 1) ? $clog2(HD) : 1;
  localparam int AW = PTR_W + 1;
  localparam int TS_W = $clog2(HD + 1);
  localparam int CW = TS_W + 1;
  localparam int SW = obfe_pkg::SUM_W;

  logic [3:0]  lvl_in_use;
  logic [3:0]  level_counter;
  logic [30:0] bp, ap, bs, as_q;
  logic [3:0]  lvl;
  logic [4:0]  lc;
  logic [32:0] den;
  logic [30:0] prev_bs, prev_as;
  logic signed [obfe_pkg::OFI_W-1:0] held_ofi;
  logic signed [obfe_pkg::SPR_W-1:0] held_spr;
  logic signed [obfe_pkg::QI_W-1:0]  held_qi;
  logic signed [obfe_pkg::QI_W-1:0]  qi;
  logic [61:0] prod_a, prod_b;
  logic [obfe_pkg::MICRO_W-1:0] micro;
  logic signed [SW-1:0] sums [9];
  logic [TS_W-1:0] ticks_seen;
  logic [PTR_W-1:0] ptr;

  logic signed [obfe_pkg::OFI_W-1:0] ofi_mem [HD];
  logic signed [obfe_pkg::SPR_W-1:0] spr_mem [HD];
  logic signed [obfe_pkg::QI_W-1:0]  qi_mem [HD];
  logic signed [obfe_pkg::OFI_W-1:0] rd_ofi;
  logic signed [obfe_pkg::SPR_W-1:0] rd_spr;
  logic signed [obfe_pkg::QI_W-1:0]  rd_qi;

  logic [4:0]  lc_raw, lc_eff;
  logic [3:0]  lvl_eff;
  logic [1:0]  ks, kw;
  logic [CW-1:0] wl, wl_gap, cnt, ts1;
  logic [AW-1:0] addr_sum;
  logic [PTR_W-1:0] rd_addr;
  logic signed [SW-1:0] v_ext, rd_ext, sum_k;
  logic [SW-1:0] sum_mag;
  logic [63:0] mean_num;
  logic [30:0] qi_mag;
  logic signed [obfe_pkg::OFI_W-1:0] ofi_now;
  logic [obfe_pkg::NUM_W-1:0] div_num;
  logic [obfe_pkg::DEN_W-1:0] div_den;
  logic [obfe_pkg::BITS_W-1:0] div_bits;
  logic div_start, div_done;
  logic [obfe_pkg::NUM_W-1:0] quot;
  logic [63:0] emit_val;
  logic [4:0]  emit_idx;

  // effective level count and level of the arriving word
  assign lc_raw = {1'b0, lvl_in_use};
  always_comb begin
    if (lc_raw == 5'd0) begin
      lc_eff = 5'd1;
    end else if (lc_raw > 5'(MAX_LEVEL_COUNT)) begin
      lc_eff = 5'(MAX_LEVEL_COUNT);
    end else begin
      lc_eff = lc_raw;
    end
  end
  assign lvl_eff = ({1'b0, level_counter} >= lc_eff) ? 4'd0 : level_counter;

  assign qi_mag = (bs >= as_q) ? (bs - as_q) : (as_q - bs);
  assign ofi_now = (obfe_pkg::OFI_W'(bs) - obfe_pkg::OFI_W'(prev_bs))
                 - (obfe_pkg::OFI_W'(as_q) - obfe_pkg::OFI_W'(prev_as));

  // rolling slot selection
  assign ks = obfe_pkg::k_sig(cmd.k);
  assign kw = obfe_pkg::k_win(cmd.k);
  always_comb begin
    case (kw)
      2'd0: wl = CW'(WINDOW_SHORT);
      2'd1: wl = CW'(WINDOW_MID);
      default: wl = CW'(WINDOW_LONG);
    endcase
    wl_gap = CW'(HD) - wl;
  end
  assign addr_sum = {1'b0, ptr} + AW'(wl_gap);
  assign rd_addr = (addr_sum >= AW'(HD)) ? PTR_W'(addr_sum - AW'(HD)) : PTR_W'(addr_sum);
  assign ts1 = CW'(ticks_seen) + CW'(1);
  assign cnt = (ts1 < wl) ? ts1 : wl;

  always_comb begin
    case (ks)
      2'd0: begin
        v_ext = SW'(held_ofi);
        rd_ext = SW'(rd_ofi);
      end
      2'd1: begin
        v_ext = SW'(held_spr);
        rd_ext = SW'(rd_spr);
      end
      default: begin
        v_ext = SW'(held_qi);
        rd_ext = SW'(rd_qi);
      end
    endcase
  end

  assign sum_k = sums[cmd.k];
  assign sum_mag = sum_k[SW-1] ? SW'(-sum_k) : SW'(sum_k);
  assign mean_num = (ks == 2'd2) ? 64'(sum_mag) : {sum_mag, 16'd0};

  // divider operand selection, dividend left aligned to the step count
  always_comb begin
    div_start = 1'b0;
    div_num = '0;
    div_den = den;
    div_bits = obfe_pkg::BITS_W'(48);
    if (cmd.qi_start) begin
      div_start = 1'b1;
      div_num = {1'b0, qi_mag, 48'd0};
    end else if (cmd.mc_start) begin
      div_start = 1'b1;
      div_num = {1'b0, 63'(prod_a) + 63'(prod_b), 16'd0};
      div_bits = obfe_pkg::BITS_W'(80);
    end else if (cmd.mean_start) begin
      div_start = 1'b1;
      div_num = {mean_num, 16'd0};
      div_den = obfe_pkg::DEN_W'(cnt);
      div_bits = obfe_pkg::BITS_W'(64);
    end
  end

  obfe_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .bits  (div_bits),
    .done  (div_done),
    .quot  (quot)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      lvl_in_use <= 4'd5;
      level_counter <= '0;
      prev_bs <= '0;
      prev_as <= '0;
      held_ofi <= '0;
      held_spr <= '0;
      held_qi <= '0;
      ticks_seen <= '0;
      ptr <= '0;
      for (int i = 0; i < 9; i++) begin
        sums[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        lvl_in_use <= cfg_data;
      end
      if (cmd.load) begin
        level_counter <= ({1'b0, lvl_eff} + 5'd1 == lc_eff) ? 4'd0 : lvl_eff + 4'd1;
      end
      if (cmd.mc_save) begin
        prev_bs <= bs;
        prev_as <= as_q;
        held_ofi <= ofi_now;
        held_spr <= obfe_pkg::SPR_W'({1'b0, ap}) - obfe_pkg::SPR_W'({1'b0, bp});
        held_qi <= qi;
      end
      if (cmd.sum_upd) begin
        sums[cmd.k] <= sum_k + v_ext
                     - ((CW'(ticks_seen) >= wl) ? rd_ext : SW'(0));
      end
      if (cmd.hist_commit) begin
        ptr <= (ptr == PTR_W'(HD - 1)) ? '0 : ptr + PTR_W'(1);
        if (ticks_seen < TS_W'(HD)) begin
          ticks_seen <= ticks_seen + TS_W'(1);
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bp <= bid_price;
      ap <= ask_price;
      bs <= bid_size;
      as_q <= ask_size;
      lvl <= lvl_eff;
      lc <= lc_eff;
      den <= 33'(bid_size) + 33'(ask_size);
    end
    if (cmd.qi_save) begin
      if (den == '0) begin
        qi <= '0;
      end else if (as_q > bs) begin
        qi <= -obfe_pkg::QI_W'(quot[16:0]);
      end else begin
        qi <= obfe_pkg::QI_W'(quot[16:0]);
      end
    end
    if (cmd.mul_a) begin
      prod_a <= bp * as_q;
    end
    if (cmd.mul_b) begin
      prod_b <= ap * bs;
    end
    if (cmd.mc_save) begin
      micro <= (den == '0) ? '0 : quot[obfe_pkg::MICRO_W-1:0];
    end
  end

  // history rings
  always_ff @(posedge clk) begin
    if (cmd.hist_commit) begin
      ofi_mem[ptr] <= held_ofi;
      spr_mem[ptr] <= held_spr;
      qi_mem[ptr] <= held_qi;
    end
    if (cmd.mem_rd) begin
      rd_ofi <= ofi_mem[rd_addr];
      rd_spr <= spr_mem[rd_addr];
      rd_qi <= qi_mem[rd_addr];
    end
  end

  // result word
  always_comb begin
    emit_idx = 5'd0;
    case (cmd.emit_sel)
      obfe_pkg::EMIT_MID: begin
        emit_val = {17'd0, 32'(bp) + 32'(ap), 15'd0};
      end
      obfe_pkg::EMIT_SPR: begin
        emit_idx = 5'd1;
        emit_val = {{16{held_spr[obfe_pkg::SPR_W-1]}}, held_spr, 16'd0};
      end
      obfe_pkg::EMIT_OFI: begin
        emit_idx = 5'd2;
        emit_val = {{14{held_ofi[obfe_pkg::OFI_W-1]}}, held_ofi, 16'd0};
      end
      obfe_pkg::EMIT_MICRO: begin
        emit_idx = 5'd3;
        emit_val = {17'd0, micro};
      end
      obfe_pkg::EMIT_QI: begin
        emit_idx = 5'd4 + 5'(lvl);
        emit_val = 64'(qi);
      end
      obfe_pkg::EMIT_MEAN: begin
        emit_idx = 5'd4 + lc + 5'(cmd.k);
        emit_val = sum_k[SW-1] ? -quot[63:0] : quot[63:0];
      end
      default: begin
        emit_val = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      feature_index <= emit_idx;
      feature_value <= emit_val;
      last_of_tick <= (cmd.emit_sel == obfe_pkg::EMIT_MEAN) && (cmd.k == obfe_pkg::LAST_K);
    end
  end

  assign stat.den_zero = (den == '0);
  assign stat.is_top = (lvl == 4'd0);
  assign stat.is_last = ({1'b0, lvl} + 5'd1 == lc);
  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid || !out_stall;

endmodule

// ----- design/obfe_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obfe_ctrl
// sequencer that steps the datapath through one level word
// ----------------------------------------------------------------------------
module obfe_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  obfe_pkg::obfe_stat_t stat,
  output obfe_pkg::obfe_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_QI_GO = 4'd1;
  localparam logic [3:0] S_QI_WAIT = 4'd2;
  localparam logic [3:0] S_MUL_A = 4'd3;
  localparam logic [3:0] S_MUL_B = 4'd4;
  localparam logic [3:0] S_MC_GO = 4'd5;
  localparam logic [3:0] S_MC_WAIT = 4'd6;
  localparam logic [3:0] S_TOP_EMIT = 4'd7;
  localparam logic [3:0] S_QI_EMIT = 4'd8;
  localparam logic [3:0] S_RD = 4'd9;
  localparam logic [3:0] S_SUM = 4'd10;
  localparam logic [3:0] S_MEAN_GO = 4'd11;
  localparam logic [3:0] S_MEAN_WAIT = 4'd12;
  localparam logic [3:0] S_MEAN_EMIT = 4'd13;
  localparam logic [3:0] S_COMMIT = 4'd14;

  logic [3:0] state, state_next;
  logic [3:0] k, k_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.k = k;
    state_next = state;
    k_next = k;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_QI_GO;
        end
      end
      S_QI_GO: begin
        if (stat.den_zero) begin
          cmd.qi_save = 1'b1;
          state_next = stat.is_top ? S_MUL_A : S_QI_EMIT;
        end else begin
          cmd.qi_start = 1'b1;
          state_next = S_QI_WAIT;
        end
      end
      S_QI_WAIT: begin
        if (stat.div_done) begin
          cmd.qi_save = 1'b1;
          state_next = stat.is_top ? S_MUL_A : S_QI_EMIT;
        end
      end
      S_MUL_A: begin
        cmd.mul_a = 1'b1;
        state_next = S_MUL_B;
      end
      S_MUL_B: begin
        cmd.mul_b = 1'b1;
        state_next = S_MC_GO;
      end
      S_MC_GO: begin
        if (stat.den_zero) begin
          cmd.mc_save = 1'b1;
          k_next = 4'd0;
          state_next = S_TOP_EMIT;
        end else begin
          cmd.mc_start = 1'b1;
          state_next = S_MC_WAIT;
        end
      end
      S_MC_WAIT: begin
        if (stat.div_done) begin
          cmd.mc_save = 1'b1;
          k_next = 4'd0;
          state_next = S_TOP_EMIT;
        end
      end
      S_TOP_EMIT: begin
        case (k)
          4'd0: cmd.emit_sel = obfe_pkg::EMIT_MID;
          4'd1: cmd.emit_sel = obfe_pkg::EMIT_SPR;
          4'd2: cmd.emit_sel = obfe_pkg::EMIT_OFI;
          default: cmd.emit_sel = obfe_pkg::EMIT_MICRO;
        endcase
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          k_next = k + 4'd1;
          if (k == 4'd3) begin
            state_next = S_QI_EMIT;
          end
        end
      end
      S_QI_EMIT: begin
        cmd.emit_sel = obfe_pkg::EMIT_QI;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          k_next = 4'd0;
          state_next = stat.is_last ? S_RD : S_IDLE;
        end
      end
      S_RD: begin
        cmd.mem_rd = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum_upd = 1'b1;
        state_next = S_MEAN_GO;
      end
      S_MEAN_GO: begin
        cmd.mean_start = 1'b1;
        state_next = S_MEAN_WAIT;
      end
      S_MEAN_WAIT: begin
        if (stat.div_done) begin
          state_next = S_MEAN_EMIT;
        end
      end
      S_MEAN_EMIT: begin
        cmd.emit_sel = obfe_pkg::EMIT_MEAN;
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (k == obfe_pkg::LAST_K) begin
            state_next = S_COMMIT;
          end else begin
            k_next = k + 4'd1;
            state_next = S_RD;
          end
        end
      end
      S_COMMIT: begin
        cmd.hist_commit = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k <= '0;
    end else begin
      state <= state_next;
      k <= k_next;
    end
  end

endmodule

// ----- design/order_book_feature_engine_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// order_book_feature_engine_top
// book level features: mid, spread, ofi, microprice, queue imbalance, means
// ----------------------------------------------------------------------------
// work: every level computes its imbalance, level 0 adds mid, spread, ofi
//   and microprice, and the last level of a tick adds the 9 rolling means
// throughput: one level word at a time, set by the one-bit-per-cycle
//   shared divider (48 steps imbalance, 80 microprice, 64 per mean)
// reset: synchronous, clears sums, tick count, ring pointer and top sizes;
//   level count returns to 5, history rings need no clearing
module order_book_feature_engine_top #(
  parameter int MAX_LEVEL_COUNT = 8,
  parameter int WINDOW_SHORT = 16,
  parameter int WINDOW_MID = 64,
  parameter int WINDOW_LONG = 256
) (
  input  logic               clk,
  input  logic               rst,
  // level count register
  input  logic               cfg_we,
  input  logic [3:0]         cfg_data,
  // level words
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [30:0]        bid_price,
  input  logic [30:0]        ask_price,
  input  logic [30:0]        bid_size,
  input  logic [30:0]        ask_size,
  // feature words
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         feature_index,
  output logic signed [63:0] feature_value,
  output logic               last_of_tick
);

  obfe_pkg::obfe_cmd_t  cmd;
  obfe_pkg::obfe_stat_t stat;

  // sequencer: one state per step, waits on divider and output register
  obfe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: operands, shared divider, rings, sums, output register
  obfe_dp #(
    .MAX_LEVEL_COUNT (MAX_LEVEL_COUNT),
    .WINDOW_SHORT    (WINDOW_SHORT),
    .WINDOW_MID      (WINDOW_MID),
    .WINDOW_LONG     (WINDOW_LONG)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .bid_price     (bid_price),
    .ask_price     (ask_price),
    .bid_size      (bid_size),
    .ask_size      (ask_size),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .feature_index (feature_index),
    .feature_value (feature_value),
    .last_of_tick  (last_of_tick)
  );

  // an accepted word keeps the input stalled on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accept");

  // the tick marker only comes with a rolling mean index
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_of_tick) |-> (feature_index >= 5'd13))
    else $error("tick marker on non-mean feature");

  // the input is never taken while a level 0 top feature word (index below 4) is pending
  a_no_accept_before_mean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && feature_index < 5'd4) |-> in_stall)
    else $error("input taken during level 0 output");

endmodule
